FILE: hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_pkg
// shared types, opcodes and constants of the modular exponentiation unit
// ----------------------------------------------------------------------------
package mexp_pkg;

  localparam int IDX_W       = 4;
  localparam int BIT_W       = 9;
  localparam int LC_W        = 3;
  localparam int IN_TDATA_W  = 104;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] REQ_MOD   = 2'd0;
  localparam logic [1:0] REQ_ONE   = 2'd1;
  localparam logic [1:0] REQ_BASE  = 2'd2;
  localparam logic [1:0] REQ_START = 2'd3;

  localparam logic [1:0] CFG_LIMBS = 2'd0;
  localparam logic [1:0] CFG_MODE  = 2'd1;
  localparam logic [1:0] CFG_NINV  = 2'd2;

  localparam logic SEL_ACC = 1'b0;
  localparam logic SEL_SQ  = 1'b1;

  typedef logic [4:0] op_t;

  localparam op_t OP_NONE        = 5'd0;
  localparam op_t OP_LOAD        = 5'd1;
  localparam op_t OP_ACC_BASE    = 5'd2;
  localparam op_t OP_INIT_ONE    = 5'd3;
  localparam op_t OP_RUN_INIT    = 5'd4;
  localparam op_t OP_CLR_PROD    = 5'd5;
  localparam op_t OP_CLR_CARRY   = 5'd6;
  localparam op_t OP_MUL_PROD    = 5'd7;
  localparam op_t OP_MUL_M       = 5'd8;
  localparam op_t OP_MUL_RED     = 5'd9;
  localparam op_t OP_MADD        = 5'd10;
  localparam op_t OP_PUT_CARRY   = 5'd11;
  localparam op_t OP_SET_M       = 5'd12;
  localparam op_t OP_PROP        = 5'd13;
  localparam op_t OP_MONT_FIN    = 5'd14;
  localparam op_t OP_PLAIN_CLR   = 5'd15;
  localparam op_t OP_PLAIN_STEP  = 5'd16;
  localparam op_t OP_PLAIN_DONE  = 5'd17;
  localparam op_t OP_PUBLISH     = 5'd18;
  localparam op_t OP_PUBLISH_ERR = 5'd19;

  typedef struct packed {
    op_t              op;
    logic             sel;
    logic [IDX_W-1:0] xi;
    logic [IDX_W-1:0] yi;
    logic [IDX_W-1:0] widx;
    logic [BIT_W-1:0] bitn;
  } cmd_t;

  typedef struct packed {
    logic            mul_done;
    logic            obuf_empty;
    logic [LC_W-1:0] t;
    logic            mont;
  } stat_t;

endpackage

FILE: hw/rtl/mexp_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_mul
// limb multiplier: full double-limb product from four half-width products
// ----------------------------------------------------------------------------
module mexp_mul #(
  parameter int LIMB_BITS = 64
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [LIMB_BITS-1:0] a,
  input  logic [LIMB_BITS-1:0] b,
  output logic                 done,
  output logic [LIMB_BITS-1:0] prod_lo,
  output logic [LIMB_BITS-1:0] prod_hi
);

  localparam int L    = LIMB_BITS;
  localparam int HALF = (LIMB_BITS + 1) / 2;

  logic             busy;
  logic [2:0]       cnt;
  logic [L-1:0]     xa;
  logic [L-1:0]     xb;
  logic [2*HALF-1:0] pp;
  logic [1:0]       code;
  logic [2*L-1:0]   acc;

  logic [HALF-1:0]   opx;
  logic [HALF-1:0]   opy;
  logic [2*HALF-1:0] mprod;
  logic [2*L-1:0]    shifted;

  always_comb begin
    case (cnt[1:0])
      2'd0: begin
        opx = xa[HALF-1:0];
        opy = xb[HALF-1:0];
      end
      2'd1: begin
        opx = xa[HALF-1:0];
        opy = HALF'(xb[L-1:HALF]);
      end
      2'd2: begin
        opx = HALF'(xa[L-1:HALF]);
        opy = xb[HALF-1:0];
      end
      default: begin
        opx = HALF'(xa[L-1:HALF]);
        opy = HALF'(xb[L-1:HALF]);
      end
    endcase
  end

  assign mprod = (2*HALF)'(opx) * (2*HALF)'(opy);

  always_comb begin
    case (code) inside
      2'd0:    shifted = (2*L)'(pp);
      2'd1,
      2'd2:    shifted = (2*L)'(pp) << HALF;
      default: shifted = (2*L)'(pp) << (2*HALF);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 3'd0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 3'd0;
      end else if (busy) begin
        cnt <= cnt + 3'd1;
        if (cnt == 3'd4) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      xa  <= a;
      xb  <= b;
      acc <= '0;
    end else if (busy) begin
      if (cnt != 3'd4) begin
        pp   <= mprod;
        code <= cnt[1:0];
      end
      if (cnt != 3'd0) begin
        acc <= acc + shifted;
      end
    end
  end

  assign prod_lo = acc[L-1:0];
  assign prod_hi = acc[2*L-1:L];

endmodule

FILE: hw/rtl/mexp_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_datapath
// operand stores, product buffer, reduction and result buffer
// ----------------------------------------------------------------------------
module mexp_datapath import mexp_pkg::*; #(
  parameter int LIMBS     = 4,
  parameter int LIMB_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  logic [1:0]             req_type,
  input  logic [1:0]             limb_index,
  input  logic [63:0]            limb_value,
  input  logic                   cfg_valid,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  output logic                   m_tuser
);

  localparam int L      = LIMB_BITS;
  localparam int MAXT   = (LIMBS < 4) ? LIMBS : 4;
  localparam int PL     = 2 * MAXT + 1;
  localparam int RW     = (MAXT + 1) * L;
  localparam int S_W    = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int A_W    = (MAXT > 1) ? $clog2(MAXT) : 1;
  localparam int P_W    = $clog2(PL);
  localparam int FB_W   = $clog2(PL * L);

  typedef logic [L-1:0] limb_t;

  limb_t mod_st  [LIMBS];
  limb_t one_st  [LIMBS];
  limb_t base_st [LIMBS];
  limb_t acc     [MAXT];
  limb_t sq      [MAXT];
  limb_t prod    [PL];
  limb_t obuf    [MAXT];
  limb_t carry;
  limb_t mreg;
  logic [RW-1:0] rv;

  logic [2:0]  limbs_cfg;
  logic        mont_cfg;
  logic [63:0] ninv_cfg;

  logic           ovalid;
  logic           oerr;
  logic [A_W-1:0] opos;
  logic [A_W-1:0] olast;

  logic [LC_W-1:0] t_use;
  logic            mul_start;
  logic            mul_done;
  limb_t           ma;
  limb_t           mb;
  limb_t           mul_lo;
  limb_t           mul_hi;

  logic [RW-1:0]   nxv;
  logic [RW-1:0]   tmask;
  logic [RW-1:0]   rmont;
  logic [RW-1:0]   mont_res;
  logic [RW-1:0]   plain_sh;
  logic [RW-1:0]   plain_res;
  logic [PL*L-1:0] pflat;
  logic            bitval;
  logic [L+1:0]    msum;
  logic [L:0]      psum;
  limb_t           pw;

  always_comb begin
    if (limbs_cfg == 3'd0) begin
      t_use = LC_W'(1);
    end else if (int'(limbs_cfg) > MAXT) begin
      t_use = LC_W'(MAXT);
    end else begin
      t_use = limbs_cfg;
    end
  end

  assign mul_start = (cmd.op == OP_MUL_PROD) || (cmd.op == OP_MUL_M) ||
                     (cmd.op == OP_MUL_RED);

  always_comb begin
    case (cmd.op)
      OP_MUL_PROD: begin
        ma = sq[cmd.xi[A_W-1:0]];
        mb = (cmd.sel == SEL_SQ) ? sq[cmd.yi[A_W-1:0]] : acc[cmd.yi[A_W-1:0]];
      end
      OP_MUL_M: begin
        ma = prod[cmd.xi[P_W-1:0]];
        mb = ninv_cfg[L-1:0];
      end
      OP_MUL_RED: begin
        ma = mod_st[cmd.xi[S_W-1:0]];
        mb = mreg;
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  mexp_mul #(
    .LIMB_BITS (LIMB_BITS)
  ) u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (ma),
    .b       (mb),
    .done    (mul_done),
    .prod_lo (mul_lo),
    .prod_hi (mul_hi)
  );

  always_comb begin
    nxv   = '0;
    tmask = '0;
    rmont = '0;
    pflat = '0;
    for (int n = 0; n < MAXT; n++) begin
      if (n < int'(t_use)) begin
        nxv[n*L +: L] = mod_st[n];
      end
    end
    for (int n = 0; n <= MAXT; n++) begin
      if (n <= int'(t_use)) begin
        tmask[n*L +: L] = '1;
        rmont[n*L +: L] = prod[P_W'(int'(t_use) + n)];
      end
    end
    for (int n = 0; n < PL; n++) begin
      pflat[n*L +: L] = prod[n];
    end
  end

  assign mont_res  = (rmont >= nxv) ? (rmont - nxv) : rmont;
  assign bitval    = pflat[FB_W'(cmd.bitn)];
  assign plain_sh  = {rv[RW-2:0], bitval} & tmask;
  assign plain_res = ((|nxv) && (plain_sh >= nxv)) ? (plain_sh - nxv) : plain_sh;

  assign pw   = prod[cmd.widx[P_W-1:0]];
  assign msum = (L+2)'(pw) + (L+2)'(mul_lo) + (L+2)'(carry);
  assign psum = (L+1)'(pw) + (L+1)'(carry);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      limbs_cfg <= 3'd4;
      mont_cfg  <= 1'b1;
      ninv_cfg  <= 64'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LIMBS: limbs_cfg <= cfg_data[2:0];
        CFG_MODE:  mont_cfg  <= cfg_data[0];
        CFG_NINV:  ninv_cfg  <= cfg_data;
        default: ;
      endcase
    end
  end

  // operand stores and working registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      OP_LOAD: begin
        if (int'(limb_index) < LIMBS) begin
          case (req_type)
            REQ_MOD:  mod_st[S_W'(limb_index)]  <= limb_value[L-1:0];
            REQ_ONE:  one_st[S_W'(limb_index)]  <= limb_value[L-1:0];
            REQ_BASE: base_st[S_W'(limb_index)] <= limb_value[L-1:0];
            default: ;
          endcase
        end
      end
      OP_ACC_BASE: begin
        for (int n = 0; n < MAXT; n++) acc[n] <= base_st[n];
      end
      OP_INIT_ONE, OP_RUN_INIT: begin
        for (int n = 0; n < MAXT; n++) begin
          if (mont_cfg) begin
            acc[n] <= one_st[n];
          end else begin
            acc[n] <= (n == 0) ? limb_t'(1) : '0;
          end
          if (cmd.op == OP_RUN_INIT) sq[n] <= base_st[n];
        end
      end
      OP_CLR_PROD: begin
        for (int n = 0; n < PL; n++) prod[n] <= '0;
        carry <= '0;
      end
      OP_CLR_CARRY: carry <= '0;
      OP_MADD: begin
        prod[cmd.widx[P_W-1:0]] <= msum[L-1:0];
        carry <= mul_hi + L'(msum[L+1:L]);
      end
      OP_PUT_CARRY: prod[cmd.widx[P_W-1:0]] <= carry;
      OP_SET_M: begin
        mreg  <= mul_lo;
        carry <= '0;
      end
      OP_PROP: begin
        prod[cmd.widx[P_W-1:0]] <= psum[L-1:0];
        carry <= L'(psum[L]);
      end
      OP_MONT_FIN: begin
        for (int n = 0; n < MAXT; n++) begin
          if (cmd.sel == SEL_SQ) sq[n] <= mont_res[n*L +: L];
          else acc[n] <= mont_res[n*L +: L];
        end
      end
      OP_PLAIN_CLR:  rv <= '0;
      OP_PLAIN_STEP: rv <= plain_res;
      OP_PLAIN_DONE: begin
        for (int n = 0; n < MAXT; n++) begin
          if (cmd.sel == SEL_SQ) sq[n] <= rv[n*L +: L];
          else acc[n] <= rv[n*L +: L];
        end
      end
      OP_PUBLISH: begin
        for (int n = 0; n < MAXT; n++) obuf[n] <= acc[n];
      end
      default: ;
    endcase
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
      oerr   <= 1'b0;
      opos   <= '0;
      olast  <= '0;
    end else begin
      if (ovalid && m_tready) begin
        if (oerr || (opos == olast)) ovalid <= 1'b0;
        else opos <= opos + A_W'(1);
      end
      if (cmd.op == OP_PUBLISH) begin
        ovalid <= 1'b1;
        oerr   <= 1'b0;
        opos   <= '0;
        olast  <= A_W'(t_use - LC_W'(1));
      end else if (cmd.op == OP_PUBLISH_ERR) begin
        ovalid <= 1'b1;
        oerr   <= 1'b1;
        opos   <= '0;
        olast  <= '0;
      end
    end
  end

  assign m_tvalid = ovalid;
  assign m_tlast  = oerr || (opos == olast);
  assign m_tuser  = oerr;
  assign m_tdata  = {6'd0, 2'(opos), (oerr ? 64'd0 : 64'(obuf[opos]))};

  assign stat.mul_done   = mul_done;
  assign stat.obuf_empty = !ovalid;
  assign stat.t          = t_use;
  assign stat.mont       = mont_cfg;

endmodule

FILE: hw/rtl/mexp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mexp_ctrl
// sequencer for square-and-multiply and the limb-serial modular products
// ----------------------------------------------------------------------------
module mexp_ctrl import mexp_pkg::*; #(
  parameter int LIMBS     = 4,
  parameter int LIMB_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [1:0]  req_type,
  input  logic [31:0] exponent,
  input  stat_t       stat,
  output cmd_t        cmd
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_LOOP    = 5'd1;
  localparam logic [4:0] S_SHIFT   = 5'd2;
  localparam logic [4:0] S_M_CLR   = 5'd3;
  localparam logic [4:0] S_P_ROW   = 5'd4;
  localparam logic [4:0] S_P_MUL   = 5'd5;
  localparam logic [4:0] S_P_WAIT  = 5'd6;
  localparam logic [4:0] S_P_CARRY = 5'd7;
  localparam logic [4:0] S_R_M     = 5'd8;
  localparam logic [4:0] S_R_MWAIT = 5'd9;
  localparam logic [4:0] S_R_MUL   = 5'd10;
  localparam logic [4:0] S_R_WAIT  = 5'd11;
  localparam logic [4:0] S_R_PROP  = 5'd12;
  localparam logic [4:0] S_MFIN    = 5'd13;
  localparam logic [4:0] S_PL_CLR  = 5'd14;
  localparam logic [4:0] S_PL_STEP = 5'd15;
  localparam logic [4:0] S_PL_DONE = 5'd16;
  localparam logic [4:0] S_DONE    = 5'd17;
  localparam logic [4:0] S_ERR     = 5'd18;

  logic [4:0]       state, state_next;
  logic [IDX_W-1:0] i, i_next;
  logic [IDX_W-1:0] j, j_next;
  logic [IDX_W-1:0] k, k_next;
  logic [BIT_W-1:0] bitn, bitn_next;
  logic [30:0]      e, e_next;
  logic             sel, sel_next;

  logic [IDX_W-1:0] t_idx;
  logic [IDX_W-1:0] t_m1;
  logic [IDX_W-1:0] t_x2;
  logic [30:0]      e_in;

  assign t_idx = IDX_W'(stat.t);
  assign t_m1  = t_idx - IDX_W'(1);
  assign t_x2  = IDX_W'({stat.t, 1'b0});
  assign e_in  = exponent[30:0];

  assign s_tready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    bitn_next  = bitn;
    e_next     = e;
    sel_next   = sel;
    cmd        = '0;
    cmd.op     = OP_NONE;
    cmd.sel    = sel;
    cmd.bitn   = bitn;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (req_type != REQ_START) begin
            cmd.op = OP_LOAD;
          end else if (exponent[31]) begin
            state_next = S_ERR;
          end else if (e_in == 31'd1) begin
            cmd.op     = OP_ACC_BASE;
            state_next = S_DONE;
          end else if (e_in == 31'd0) begin
            cmd.op     = OP_INIT_ONE;
            state_next = S_DONE;
          end else begin
            cmd.op     = OP_RUN_INIT;
            e_next     = e_in;
            state_next = S_LOOP;
          end
        end
      end
      S_LOOP: begin
        if (e[0]) begin
          sel_next   = SEL_ACC;
          state_next = S_M_CLR;
        end else begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        e_next = e >> 1;
        if (e[30:1] == 30'd0) begin
          state_next = S_DONE;
        end else begin
          sel_next   = SEL_SQ;
          state_next = S_M_CLR;
        end
      end
      S_M_CLR: begin
        cmd.op     = OP_CLR_PROD;
        i_next     = '0;
        state_next = S_P_ROW;
      end
      S_P_ROW: begin
        cmd.op     = OP_CLR_CARRY;
        j_next     = '0;
        state_next = S_P_MUL;
      end
      S_P_MUL: begin
        cmd.op     = OP_MUL_PROD;
        cmd.xi     = j;
        cmd.yi     = i;
        state_next = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (stat.mul_done) begin
          cmd.op   = OP_MADD;
          cmd.widx = i + j;
          if (j == t_m1) begin
            state_next = S_P_CARRY;
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = S_P_MUL;
          end
        end
      end
      S_P_CARRY: begin
        cmd.op   = OP_PUT_CARRY;
        cmd.widx = i + t_idx;
        if (i == t_m1) begin
          i_next = '0;
          if (stat.mont) state_next = S_R_M;
          else state_next = S_PL_CLR;
        end else begin
          i_next     = i + IDX_W'(1);
          state_next = S_P_ROW;
        end
      end
      S_R_M: begin
        cmd.op     = OP_MUL_M;
        cmd.xi     = i;
        state_next = S_R_MWAIT;
      end
      S_R_MWAIT: begin
        if (stat.mul_done) begin
          cmd.op     = OP_SET_M;
          j_next     = '0;
          state_next = S_R_MUL;
        end
      end
      S_R_MUL: begin
        cmd.op     = OP_MUL_RED;
        cmd.xi     = j;
        state_next = S_R_WAIT;
      end
      S_R_WAIT: begin
        if (stat.mul_done) begin
          cmd.op   = OP_MADD;
          cmd.widx = i + j;
          if (j == t_m1) begin
            k_next     = i + t_idx;
            state_next = S_R_PROP;
          end else begin
            j_next     = j + IDX_W'(1);
            state_next = S_R_MUL;
          end
        end
      end
      S_R_PROP: begin
        cmd.op   = OP_PROP;
        cmd.widx = k;
        if (k == t_x2) begin
          if (i == t_m1) begin
            state_next = S_MFIN;
          end else begin
            i_next     = i + IDX_W'(1);
            state_next = S_R_M;
          end
        end else begin
          k_next = k + IDX_W'(1);
        end
      end
      S_MFIN: begin
        cmd.op     = OP_MONT_FIN;
        state_next = (sel == SEL_ACC) ? S_SHIFT : S_LOOP;
      end
      S_PL_CLR: begin
        cmd.op     = OP_PLAIN_CLR;
        bitn_next  = BIT_W'(2 * LIMB_BITS * int'(stat.t) - 1);
        state_next = S_PL_STEP;
      end
      S_PL_STEP: begin
        cmd.op = OP_PLAIN_STEP;
        if (bitn == '0) begin
          state_next = S_PL_DONE;
        end else begin
          bitn_next = bitn - BIT_W'(1);
        end
      end
      S_PL_DONE: begin
        cmd.op     = OP_PLAIN_DONE;
        state_next = (sel == SEL_ACC) ? S_SHIFT : S_LOOP;
      end
      S_DONE: begin
        if (stat.obuf_empty) begin
          cmd.op     = OP_PUBLISH;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (stat.obuf_empty) begin
          cmd.op     = OP_PUBLISH_ERR;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      bitn  <= '0;
      e     <= '0;
      sel   <= SEL_ACC;
    end else begin
      state <= state_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      bitn  <= bitn_next;
      e     <= e_next;
      sel   <= sel_next;
    end
  end

endmodule

FILE: hw/rtl/modular_exponentiation_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// modular_exponentiation_unit
// multi-limb modular exponentiation by right-to-left square-and-multiply
// ----------------------------------------------------------------------------
// Load beats (modulus, Montgomery one, base limbs) are taken while the unit is
// idle. A start beat with exponent 0 or 1, or a negative exponent, gives its
// result once the result buffer is free. Otherwise each exponent bit up to the
// highest set one passes through the loop and shift control states, with one
// modular product when the bit is set and one squaring (none after the top
// bit). Every limb product runs through a shared half-width multiplier, and a
// plain-mode product is reduced by a bit-serial remainder loop. One item is
// worked on at a time; results leave through a buffer, so the next item is
// taken while the previous result is still draining.
// ----------------------------------------------------------------------------
module modular_exponentiation_unit import mexp_pkg::*; #(
  parameter int LIMBS     = 4,
  parameter int LIMB_BITS = 64
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // limb_index, limb_value, exponent
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  // req_type
  input  logic [1:0]             s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // result_limb, result_index
  output logic [OUT_TDATA_W-1:0] m_tdata,
  output logic                   m_tlast,
  // negative_exponent_error
  output logic                   m_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [63:0]            cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  mexp_ctrl #(
    .LIMBS     (LIMBS),
    .LIMB_BITS (LIMB_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .req_type (s_tuser),
    .exponent (s_tdata[97:66]),
    .stat     (stat),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .LIMBS     (LIMBS),
    .LIMB_BITS (LIMB_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req_type   (s_tuser),
    .limb_index (s_tdata[1:0]),
    .limb_value (s_tdata[65:2]),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

  a_err_beat: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> (m_tlast && (m_tdata[65:0] == 66'd0)))
    else $error("error beat malformed");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && !m_tuser) |->
      (m_tdata[65:64] == 2'(stat.t - LC_W'(1))))
    else $error("last beat at wrong limb index");

  a_publish: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_PUBLISH || cmd.op == OP_PUBLISH_ERR) |=> m_tvalid)
    else $error("published result not presented");

endmodule
